FILE: rtl/core/srtm_pkg.sv
// Package for the sorted insert with merge block: sizes, codes and item types.
// Used by srtm_cell and by sorted_insert_with_merge; depends on nothing.
package srtm_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int FLAG_BITS_DEF   = 32;

  localparam int POS_W   = 32;
  localparam int FLAG_W  = 32;
  localparam int INDEX_W = 6;
  localparam int STAT_W  = 3;
  localparam int HELD_W  = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_MERGED    = 3'd1,
    STAT_DROPPED   = 3'd2,
    STAT_READ_OK   = 3'd3,
    STAT_READ_MISS = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [POS_W-1:0]  position;
    logic [FLAG_W-1:0]        tail_flags;
    logic [FLAG_W-1:0]        nose_flags;
    logic [INDEX_W-1:0]       read_index;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic [INDEX_W-1:0]       slot;
    logic signed [POS_W-1:0]  entry_position;
    logic [FLAG_W-1:0]        entry_tail_flags;
    logic [FLAG_W-1:0]        entry_nose_flags;
    logic [HELD_W-1:0]        entries_held;
  } res_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic mrg_en;
  } cell_ctl_t;

endpackage

FILE: rtl/core/srtm_cell.sv
// One slot of the sorted table: holds an entry, compares it with a new position,
// merges or loads the new entry or shifts in the left one. Depends on srtm_pkg.
module srtm_cell #(
  parameter int FLAG_BITS = srtm_pkg::FLAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srtm_pkg::cell_ctl_t              ctl,
  input  logic                             cell_valid,
  input  logic signed [srtm_pkg::POS_W-1:0] new_position,
  input  logic [FLAG_BITS-1:0]             new_tail,
  input  logic [FLAG_BITS-1:0]             new_nose,
  input  logic                             left_gt,
  input  logic signed [srtm_pkg::POS_W-1:0] left_position,
  input  logic [FLAG_BITS-1:0]             left_tail,
  input  logic [FLAG_BITS-1:0]             left_nose,
  output logic                             gt,
  output logic                             eq,
  output logic signed [srtm_pkg::POS_W-1:0] position,
  output logic [FLAG_BITS-1:0]             tail_flags,
  output logic [FLAG_BITS-1:0]             nose_flags
);

  logic point;
  logic after;

  assign point = left_gt && !gt;
  assign after = !left_gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      gt <= 1'b0;
      eq <= 1'b0;
    end else if (ctl.cmp_en) begin
      gt <= cell_valid && (new_position > position);
      eq <= cell_valid && (new_position == position);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mrg_en && point) begin
      tail_flags <= tail_flags | new_tail;
      nose_flags <= nose_flags | new_nose;
    end else if (ctl.ins_en && point) begin
      position   <= new_position;
      tail_flags <= new_tail;
      nose_flags <= new_nose;
    end else if (ctl.ins_en && after) begin
      position   <= left_position;
      tail_flags <= left_tail;
      nose_flags <= left_nose;
    end
  end

endmodule

FILE: rtl/core/sorted_insert_with_merge.sv
// Top level of the sorted insert with merge block: command control, the row of
// srtm_cell slots, result selection and the result register. Depends on srtm_pkg.
//
//   channel  | handshake         | payload | accepted when
//   ---------+-------------------+---------+--------------------------------
//   command  | start / busy      | cmd     | rising edge with start && !busy
//   result   | done              | result  | rising edge ending the done cycle
//
// Each item passes through the accept cycle, a compare state in which every cell
// compares its entry with the new position, and an update state in which the cells
// merge, load or shift. The result shows with done in the cycle after the update
// state, when busy is already low, so a new item can be taken in that same cycle.
// Reset empties the table at once; entry storage is not cleared.
// The receiver cannot stall; done is high for one cycle only per result.
module sorted_insert_with_merge #(
  parameter int TABLE_DEPTH = srtm_pkg::TABLE_DEPTH_DEF,
  parameter int FLAG_BITS   = srtm_pkg::FLAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  srtm_pkg::cmd_t cmd,
  output logic           done,
  output srtm_pkg::res_t result
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  srtm_pkg::state_t    state;
  srtm_pkg::state_t    state_next;
  srtm_pkg::cmd_t      cmd_q;
  srtm_pkg::cell_ctl_t ctl;
  srtm_pkg::res_t      result_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic                merge_hit;
  logic                room;
  logic                read_hit;
  logic [FLAG_BITS-1:0] new_tail;
  logic [FLAG_BITS-1:0] new_nose;

  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] gt_vec;
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] left_gt;
  logic [TABLE_DEPTH-1:0] pt_vec;
  logic signed [srtm_pkg::POS_W-1:0] pos_arr  [TABLE_DEPTH];
  logic [FLAG_BITS-1:0]              tail_arr [TABLE_DEPTH];
  logic [FLAG_BITS-1:0]              nose_arr [TABLE_DEPTH];

  logic [srtm_pkg::INDEX_W-1:0] pt_slot;
  logic [srtm_pkg::POS_W-1:0]   pt_pos;
  logic [FLAG_BITS-1:0]         pt_tail;
  logic [FLAG_BITS-1:0]         pt_nose;
  logic [srtm_pkg::POS_W-1:0]   rd_pos;
  logic [FLAG_BITS-1:0]         rd_tail;
  logic [FLAG_BITS-1:0]         rd_nose;

  assign busy     = (state != srtm_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign new_tail = FLAG_BITS'(cmd_q.tail_flags);
  assign new_nose = FLAG_BITS'(cmd_q.nose_flags);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (i < int'(count));
    assign pt_vec[i]     = left_gt[i] && !gt_vec[i];
    if (i == 0) begin : g_first
      srtm_cell #(.FLAG_BITS(FLAG_BITS)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .cell_valid(cell_valid[i]),
        .new_position(cmd_q.position), .new_tail(new_tail), .new_nose(new_nose),
        .left_gt(left_gt[i]), .left_position('0), .left_tail('0), .left_nose('0),
        .gt(gt_vec[i]), .eq(eq_vec[i]), .position(pos_arr[i]),
        .tail_flags(tail_arr[i]), .nose_flags(nose_arr[i])
      );
      assign left_gt[i] = 1'b1;
    end else begin : g_rest
      srtm_cell #(.FLAG_BITS(FLAG_BITS)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .cell_valid(cell_valid[i]),
        .new_position(cmd_q.position), .new_tail(new_tail), .new_nose(new_nose),
        .left_gt(left_gt[i]), .left_position(pos_arr[i-1]),
        .left_tail(tail_arr[i-1]), .left_nose(nose_arr[i-1]),
        .gt(gt_vec[i]), .eq(eq_vec[i]), .position(pos_arr[i]),
        .tail_flags(tail_arr[i]), .nose_flags(nose_arr[i])
      );
      assign left_gt[i] = gt_vec[i-1];
    end
  end

  always_comb begin
    pt_slot = '0;
    pt_pos  = '0;
    pt_tail = '0;
    pt_nose = '0;
    rd_pos  = '0;
    rd_tail = '0;
    rd_nose = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pt_vec[i]) begin
        pt_slot = pt_slot | srtm_pkg::INDEX_W'(i);
        pt_pos  = pt_pos  | pos_arr[i];
        pt_tail = pt_tail | tail_arr[i];
        pt_nose = pt_nose | nose_arr[i];
      end
      if (int'(cmd_q.read_index) == i) begin
        rd_pos  = rd_pos  | pos_arr[i];
        rd_tail = rd_tail | tail_arr[i];
        rd_nose = rd_nose | nose_arr[i];
      end
    end
  end

  assign merge_hit = |eq_vec;
  assign room      = (int'(count) < TABLE_DEPTH);
  assign read_hit  = (int'(cmd_q.read_index) < int'(count));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtm_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == srtm_pkg::ST_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (state == srtm_pkg::ST_UPD) begin
      result <= result_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    ctl         = '0;
    result_next = '0;
    unique case (state)
      srtm_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = srtm_pkg::ST_CMP;
        end
      end
      srtm_pkg::ST_CMP: begin
        ctl.cmp_en = 1'b1;
        state_next = srtm_pkg::ST_UPD;
      end
      srtm_pkg::ST_UPD: begin
        state_next = srtm_pkg::ST_IDLE;
        case (cmd_q.operation)
          srtm_pkg::OP_INSERT: begin
            if (merge_hit) begin
              ctl.mrg_en                   = 1'b1;
              result_next.status           = srtm_pkg::STAT_MERGED;
              result_next.slot             = pt_slot;
              result_next.entry_position   = pt_pos;
              result_next.entry_tail_flags = srtm_pkg::FLAG_W'(pt_tail | new_tail);
              result_next.entry_nose_flags = srtm_pkg::FLAG_W'(pt_nose | new_nose);
            end else if (room) begin
              ctl.ins_en                   = 1'b1;
              count_next                   = count + 1'b1;
              result_next.status           = srtm_pkg::STAT_INSERTED;
              result_next.slot             = pt_slot;
              result_next.entry_position   = cmd_q.position;
              result_next.entry_tail_flags = srtm_pkg::FLAG_W'(new_tail);
              result_next.entry_nose_flags = srtm_pkg::FLAG_W'(new_nose);
            end else begin
              result_next.status = srtm_pkg::STAT_DROPPED;
            end
          end
          srtm_pkg::OP_READ: begin
            result_next.slot = cmd_q.read_index;
            if (read_hit) begin
              result_next.status           = srtm_pkg::STAT_READ_OK;
              result_next.entry_position   = rd_pos;
              result_next.entry_tail_flags = srtm_pkg::FLAG_W'(rd_tail);
              result_next.entry_nose_flags = srtm_pkg::FLAG_W'(rd_nose);
            end else begin
              result_next.status = srtm_pkg::STAT_READ_MISS;
            end
          end
          srtm_pkg::OP_CLEAR: begin
            count_next         = '0;
            result_next.status = srtm_pkg::STAT_CLEARED;
          end
          default: begin
            result_next.status = srtm_pkg::STAT_READ_MISS;
          end
        endcase
        result_next.entries_held = srtm_pkg::HELD_W'(count_next);
      end
      default: begin
        state_next = srtm_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is still at work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= TABLE_DEPTH)
    else $error("entry count beyond table depth");

  a_point_unique: assert property (@(posedge clk) disable iff (rst)
    (state == srtm_pkg::ST_UPD) |-> $onehot0(pt_vec))
    else $error("more than one insertion point");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == srtm_pkg::STAT_INSERTED) |->
      (count == $past(count) + 1'b1))
    else $error("insert did not grow the table by one entry");
`endif

endmodule
